@@ rtl/kfi_pkg.sv @@
// Shared types, constants and codes of the keyframe interpolator.
// No dependencies.
package kfi_pkg;

  localparam int unsigned MaxKeysDef   = 16;
  localparam int unsigned TimeBitsDef  = 24;
  localparam int unsigned ValueBitsDef = 24;

  localparam int unsigned KeyIdxW  = 4;
  localparam int unsigned KeyCntW  = 5;
  localparam int unsigned DeltaW   = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned FracW    = 17;

  typedef enum logic [CfgIdxW-1:0] {
    CfgKeyCount   = 2'd0,
    CfgLoopEnable = 2'd1,
    CfgLoopIndex  = 2'd2,
    CfgSmoothMode = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    CmdLoad = 1'b0,
    CmdTick = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [KeyCntW-1:0] key_count;
    logic               loop_enable;
    logic [KeyIdxW-1:0] loop_index;
    logic               smooth_mode;
  } cfg_t;

endpackage

@@ rtl/kfi_if.sv @@
// Valid/ready channel interfaces: input item, result item, register write.
// Depends on kfi_pkg.
interface kfi_in_if #(
  parameter int unsigned TimeBits  = kfi_pkg::TimeBitsDef,
  parameter int unsigned ValueBits = kfi_pkg::ValueBitsDef
);
  logic                                valid;
  logic                                ready;
  logic                                command;
  logic [kfi_pkg::KeyIdxW-1:0]         key_slot;
  logic [TimeBits-1:0]                 key_time;
  logic signed [ValueBits-1:0]         key_x;
  logic signed [ValueBits-1:0]         key_y;
  logic [kfi_pkg::DeltaW-1:0]          delta_ms;
  modport source (output valid, command, key_slot, key_time, key_x, key_y, delta_ms,
                  input ready);
  modport sink (input valid, command, key_slot, key_time, key_x, key_y, delta_ms,
                output ready);
endinterface

interface kfi_out_if #(
  parameter int unsigned ValueBits = kfi_pkg::ValueBitsDef
);
  logic                        valid;
  logic                        ready;
  logic signed [ValueBits-1:0] out_x;
  logic signed [ValueBits-1:0] out_y;
  logic                        has_keys;
  logic [kfi_pkg::KeyIdxW-1:0] current_key;
  logic                        at_end;
  modport source (output valid, out_x, out_y, has_keys, current_key, at_end, input ready);
  modport sink (input valid, out_x, out_y, has_keys, current_key, at_end, output ready);
endinterface

interface kfi_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [kfi_pkg::CfgIdxW-1:0]   index;
  logic [kfi_pkg::CfgDataW-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/kfi_alu.sv @@
// Shared arithmetic unit: one signed multiply, or one add/subtract, per cycle.
// Depends on kfi_pkg.
module kfi_alu #(
  parameter int unsigned OpW = 34
) (
  input  logic                   mul_i,
  input  logic                   sub_i,
  input  logic signed [OpW-1:0]  a_i,
  input  logic signed [OpW-1:0]  b_i,
  output logic signed [2*OpW-1:0] y_o
);
  import kfi_pkg::*;

  // Multiply or add/subtract, sign-extended to the full result width
  always_comb begin
    if (mul_i) begin
      y_o = a_i * b_i;
    end else if (sub_i) begin
      y_o = (2*OpW)'(a_i) - (2*OpW)'(b_i);
    end else begin
      y_o = (2*OpW)'(a_i) + (2*OpW)'(b_i);
    end
  end
endmodule

@@ rtl/kfi_div.sv @@
// Restoring divider: one quotient bit per cycle, quotient of (num << 16) / den.
// Depends on kfi_pkg.
module kfi_div #(
  parameter int unsigned TimeBits = kfi_pkg::TimeBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [TimeBits-1:0] num_i,
  input  logic [TimeBits-1:0] den_i,
  output logic                done_o,
  output logic [16:0]         quo_o
);
  import kfi_pkg::*;

  localparam int unsigned DivW = TimeBits + 16;
  localparam int unsigned CntW = $clog2(DivW + 1);

  logic [DivW-1:0]     dvd_q, dvd_d;
  logic [TimeBits:0]   rem_q, rem_d;
  logic [TimeBits-1:0] den_q, den_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                busy_q, busy_d;
  logic [TimeBits:0]   trial;
  logic [TimeBits:0]   shifted;

  // Shift in one dividend bit and try a subtraction
  always_comb begin
    shifted = {rem_q[TimeBits-1:0], dvd_q[DivW-1]};
    trial   = shifted - {1'b0, den_q};
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    den_d   = den_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    if (start_i) begin
      dvd_d  = {num_i, 16'd0};
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CntW'(DivW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[TimeBits]) begin
        rem_d = trial;
        dvd_d = {dvd_q[DivW-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        dvd_d = {dvd_q[DivW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = busy_q && (cnt_q == CntW'(1));
  // Quotient is below 2^16 since num < den
  assign quo_o  = {1'b0, dvd_d[15:0]};

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !start_i) else $error("divider restarted while busy");
  a_done_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_q) else $error("divider busy after done");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q) else $error("divider failed to start");
`endif
endmodule

@@ rtl/kfi_core.sv @@
// Sequencer: keyframe table, clock, index walk, loop, fraction and blend.
// Depends on kfi_pkg, kfi_alu and kfi_div.
module kfi_core #(
  parameter int unsigned MaxKeys   = kfi_pkg::MaxKeysDef,
  parameter int unsigned TimeBits  = kfi_pkg::TimeBitsDef,
  parameter int unsigned ValueBits = kfi_pkg::ValueBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  kfi_pkg::cfg_t                 cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          command_i,
  input  logic [kfi_pkg::KeyIdxW-1:0]   key_slot_i,
  input  logic [TimeBits-1:0]           key_time_i,
  input  logic signed [ValueBits-1:0]   key_x_i,
  input  logic signed [ValueBits-1:0]   key_y_i,
  input  logic [kfi_pkg::DeltaW-1:0]    delta_ms_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [ValueBits-1:0]   out_x_o,
  output logic signed [ValueBits-1:0]   out_y_o,
  output logic                          has_keys_o,
  output logic [kfi_pkg::KeyIdxW-1:0]   current_key_o,
  output logic                          at_end_o,
  output logic                          busy_o
);
  import kfi_pkg::*;

  localparam int unsigned IdxW = $clog2(MaxKeys);
  localparam int unsigned NW   = $clog2(MaxKeys + 1);
  localparam int unsigned OpW  = ((TimeBits > ValueBits) ? TimeBits : ValueBits) + 2;
  localparam int unsigned PW   = 2 * OpW;
  localparam logic [TimeBits-1:0] TimeMax = '1;

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StRead  = 4'd1;
  localparam logic [3:0] StWalk  = 4'd2;
  localparam logic [3:0] StLoop  = 4'd3;
  localparam logic [3:0] StSpan  = 4'd4;
  localparam logic [3:0] StDiv   = 4'd5;
  localparam logic [3:0] StPow   = 4'd6;
  localparam logic [3:0] StPoly  = 4'd7;
  localparam logic [3:0] StBlend = 4'd8;
  localparam logic [3:0] StOut   = 4'd9;

  // Keyframe tables
  logic [TimeBits-1:0]         time_mem [MaxKeys];
  logic signed [ValueBits-1:0] x_mem [MaxKeys];
  logic signed [ValueBits-1:0] y_mem [MaxKeys];

  logic [3:0]          st_q, st_d;
  logic [TimeBits-1:0] elapsed_q, elapsed_d;
  logic [IdxW-1:0]     pos_q, pos_d;
  logic [IdxW-1:0]     last_q, last_d;
  logic [IdxW-1:0]     ra_q, ra_d;
  logic [TimeBits-1:0] rd_time_q;
  logic signed [ValueBits-1:0] rd_x_q, rd_y_q;
  logic [TimeBits-1:0] t0_q, t0_d;
  logic signed [ValueBits-1:0] xa_q, xa_d, ya_q, ya_d;
  logic [FracW-1:0]    t_q, t_d;
  logic [FracW-1:0]    pw_q, pw_d;
  logic signed [OpW+2:0] acc_q, acc_d;
  logic [2:0]          step_q, step_d;
  logic                ovalid_q, ovalid_d;
  logic signed [ValueBits-1:0] ox_q, ox_d, oy_q, oy_d;
  logic                ohas_q, ohas_d, oend_q, oend_d;
  logic [KeyIdxW-1:0]  okey_q, okey_d;
  logic [NW-1:0]       n_cnt;
  logic                div_start;
  logic [TimeBits-1:0] div_num, div_den;
  logic                div_done;
  logic [16:0]         div_quo;
  logic                alu_mul, alu_sub;
  logic signed [OpW-1:0] alu_a, alu_b;
  logic signed [PW-1:0]  alu_y;
  logic                accept;
  logic [TimeBits:0]   sum_sat;
  logic [IdxW-1:0]     lk;
  logic signed [PW-1:0] rnd;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (st_q == StIdle) && !ovalid_q;
  assign busy_o     = (st_q != StIdle) || ovalid_q;

  // Clamp the key count to the table size
  always_comb begin
    if (32'(cfg_i.key_count) > MaxKeys) n_cnt = NW'(MaxKeys);
    else                                n_cnt = NW'(cfg_i.key_count);
  end

  always_comb begin
    if (32'(cfg_i.loop_index) > 32'(last_q)) lk = last_q;
    else                                     lk = IdxW'(cfg_i.loop_index);
  end

  assign sum_sat = {1'b0, elapsed_q} + (TimeBits+1)'(delta_ms_i);

  // Table write and registered read
  always_ff @(posedge clk_i) begin
    if (accept && command_i == CmdLoad && 32'(key_slot_i) < MaxKeys) begin
      time_mem[IdxW'(key_slot_i)] <= key_time_i;
      x_mem[IdxW'(key_slot_i)]    <= key_x_i;
      y_mem[IdxW'(key_slot_i)]    <= key_y_i;
    end
    rd_time_q <= time_mem[ra_d];
    rd_x_q    <= x_mem[ra_d];
    rd_y_q    <= y_mem[ra_d];
  end

  kfi_alu #(.OpW(OpW)) u_alu (
    .mul_i(alu_mul), .sub_i(alu_sub), .a_i(alu_a), .b_i(alu_b), .y_o(alu_y)
  );

  kfi_div #(.TimeBits(TimeBits)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(div_quo)
  );

  // Sequencer
  always_comb begin
    st_d = st_q; elapsed_d = elapsed_q; pos_d = pos_q; last_d = last_q; ra_d = ra_q;
    t0_d = t0_q; xa_d = xa_q; ya_d = ya_q; t_d = t_q; pw_d = pw_q; acc_d = acc_q;
    step_d = step_q; ovalid_d = ovalid_q; ox_d = ox_q; oy_d = oy_q;
    ohas_d = ohas_q; oend_d = oend_q; okey_d = okey_q;
    div_start = 1'b0; div_num = '0; div_den = '1;
    alu_mul = 1'b0; alu_sub = 1'b0; alu_a = '0; alu_b = '0;
    rnd = '0;
    if (ovalid_q && out_ready_i) ovalid_d = 1'b0;
    unique case (st_q)
      StIdle: begin
        if (accept && command_i == CmdTick) begin
          if (n_cnt == '0) begin
            ovalid_d = 1'b1; ox_d = '0; oy_d = '0; ohas_d = 1'b0; oend_d = 1'b0;
            okey_d = KeyIdxW'(pos_q);
          end else begin
            last_d = IdxW'(n_cnt - 1'b1);
            if (pos_q > IdxW'(n_cnt - 1'b1)) pos_d = IdxW'(n_cnt - 1'b1);
            elapsed_d = sum_sat[TimeBits] ? TimeMax : sum_sat[TimeBits-1:0];
            st_d = StRead;
          end
        end
      end
      StRead: begin
        // Fetch the entry after the current position, or the current one at the last key
        if (pos_q < last_q) begin
          ra_d = pos_q + 1'b1;
          st_d = StWalk;
        end else begin
          ra_d = pos_q;
          st_d = StLoop;
        end
      end
      StWalk: begin
        if (elapsed_q >= rd_time_q) begin
          pos_d = ra_q;
        end else begin
          ra_d = pos_q;
          st_d = StSpan;
        end
        if (elapsed_q >= rd_time_q) st_d = StRead;
      end
      StLoop: begin
        // rd holds the entry at pos == last
        if (step_q == 3'd0) begin
          if (cfg_i.loop_enable) begin
            t0_d = rd_time_q; ra_d = lk; step_d = 3'd1;
          end else begin
            ovalid_d = 1'b1; ox_d = rd_x_q; oy_d = rd_y_q; ohas_d = 1'b1;
            oend_d = 1'b1; okey_d = KeyIdxW'(pos_q); st_d = StIdle;
          end
        end else if (step_q == 3'd1) begin
          step_d = 3'd2;
        end else begin
          // new time = time[lk] + elapsed - time[pos], saturated
          alu_a = OpW'(signed'({1'b0, elapsed_q})) - OpW'(signed'({1'b0, t0_q}));
          alu_b = OpW'(signed'({1'b0, rd_time_q}));
          if (alu_y < 0) elapsed_d = '0;
          else if (alu_y > PW'(signed'({1'b0, TimeMax}))) elapsed_d = TimeMax;
          else elapsed_d = alu_y[TimeBits-1:0];
          pos_d = lk; step_d = 3'd0;
          if (lk >= last_q) begin
            ovalid_d = 1'b1; ox_d = rd_x_q; oy_d = rd_y_q; ohas_d = 1'b1;
            oend_d = 1'b1; okey_d = KeyIdxW'(lk); st_d = StIdle;
          end else begin
            ra_d = lk; st_d = StSpan;
          end
        end
      end
      StSpan: begin
        // Step 0 waits for pos read, 1 latches it and reads next, 2 waits, 3 clamps or divides
        if (step_q == 3'd0) begin
          step_d = 3'd1;
        end else if (step_q == 3'd1) begin
          t0_d = rd_time_q; xa_d = rd_x_q; ya_d = rd_y_q;
          ra_d = pos_q + 1'b1; step_d = 3'd2;
        end else if (step_q == 3'd2) begin
          step_d = 3'd3;
        end else begin
          step_d = 3'd0;
          if (rd_time_q <= t0_q || elapsed_q >= rd_time_q) begin
            t_d = FracW'(32'h10000); st_d = StPow;
          end else if (elapsed_q <= t0_q) begin
            t_d = '0; st_d = StPow;
          end else begin
            div_start = 1'b1; div_num = elapsed_q - t0_q; div_den = rd_time_q - t0_q;
            st_d = StDiv;
          end
          if (st_d == StPow && !cfg_i.smooth_mode) begin
            st_d = StBlend; step_d = 3'd0;
          end
        end
      end
      StDiv: begin
        if (div_done) begin
          t_d = div_quo;
          st_d = cfg_i.smooth_mode ? StPow : StBlend;
        end
      end
      StPow: begin
        // Powers t2..t5 one per cycle, accumulate the polynomial
        if (step_q == 3'd0) begin
          pw_d = t_q; acc_d = '0; step_d = 3'd1;
        end else begin
          alu_mul = 1'b1;
          alu_a = OpW'(signed'({1'b0, pw_q}));
          alu_b = OpW'(signed'({1'b0, t_q}));
          pw_d = FracW'(alu_y >>> 16);
          if (step_q == 3'd2)
            acc_d = acc_q + (OpW+3)'(signed'({1'b0, pw_d})) * (OpW+3)'(10);
          if (step_q == 3'd3)
            acc_d = acc_q - (OpW+3)'(signed'({1'b0, pw_d})) * (OpW+3)'(15);
          if (step_q == 3'd4) begin
            acc_d = acc_q + (OpW+3)'(signed'({1'b0, pw_d})) * (OpW+3)'(6);
            st_d = StPoly;
          end
          step_d = step_q + 1'b1;
        end
      end
      StPoly: begin
        if (acc_q < 0) t_d = '0;
        else if (acc_q > (OpW+3)'(32'h10000)) t_d = FracW'(32'h10000);
        else t_d = FracW'(acc_q);
        step_d = 3'd0; st_d = StBlend;
      end
      StBlend: begin
        // Step 0 multiplies (b - a) by s for x, step 2 for y; rd holds entry pos+1
        alu_mul = 1'b1;
        alu_b = OpW'(signed'({1'b0, t_q}));
        if (step_q[1]) alu_a = OpW'(rd_y_q) - OpW'(ya_q);
        else           alu_a = OpW'(rd_x_q) - OpW'(xa_q);
        rnd = (alu_y + PW'(32768)) >>> 16;
        if (step_q == 3'd0) begin
          ox_d = xa_q + ValueBits'(rnd); step_d = 3'd2;
        end else begin
          oy_d = ya_q + ValueBits'(rnd); step_d = 3'd0; st_d = StOut;
        end
      end
      StOut: begin
        ovalid_d = 1'b1; ohas_d = 1'b1; oend_d = 1'b0; okey_d = KeyIdxW'(pos_q);
        st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; elapsed_q <= '0; pos_q <= '0; last_q <= '0; ra_q <= '0;
      step_q <= '0; ovalid_q <= 1'b0;
    end else begin
      st_q <= st_d; elapsed_q <= elapsed_d; pos_q <= pos_d; last_q <= last_d;
      ra_q <= ra_d; step_q <= step_d; ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t0_q <= t0_d; xa_q <= xa_d; ya_q <= ya_d; t_q <= t_d; pw_q <= pw_d; acc_q <= acc_d;
    ox_q <= ox_d; oy_q <= oy_d; ohas_q <= ohas_d; oend_q <= oend_d; okey_q <= okey_d;
  end

  assign out_valid_o   = ovalid_q;
  assign out_x_o       = ox_q;
  assign out_y_o       = oy_q;
  assign has_keys_o    = ohas_q;
  assign current_key_o = okey_q;
  assign at_end_o      = oend_q;

`ifndef SYNTHESIS
  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != StIdle) |-> (pos_q <= last_q)) else $error("position past last key");
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !out_ready_i) |=> (ovalid_q && $stable(ox_q) && $stable(oy_q)))
    else $error("result lost under stall");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != StIdle) |-> !in_ready_o) else $error("ready while working");
  a_frac_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StBlend) |-> (t_q <= FracW'(32'h10000))) else $error("fraction above one");
`endif
endmodule

@@ rtl/keyframe_interpolator_top.sv @@
// Channel   | Dir | Payload
// in_ch     | in  | command, key_slot, key_time, key_x, key_y, delta_ms
// out_ch    | out | out_x, out_y, has_keys, current_key, at_end
// cfg_ch    | in  | index, data (key_count, loop_enable, loop_index, smooth_mode)
// A tick walks the key table, uses the divider when it forms the fraction and the
// shared multiplier for the smootherstep powers. One request at a time; the result
// register holds under stall and blocks the next request until taken.
// Reset clears clock, position, state and settings; the key table is not cleared.
// Depends on kfi_pkg, kfi_if and kfi_core.
module keyframe_interpolator_top #(
  parameter int unsigned MaxKeys   = kfi_pkg::MaxKeysDef,
  parameter int unsigned TimeBits  = kfi_pkg::TimeBitsDef,
  parameter int unsigned ValueBits = kfi_pkg::ValueBitsDef
) (
  input logic       clk_i,
  input logic       rst_ni,
  kfi_in_if.sink    in_ch,
  kfi_out_if.source out_ch,
  kfi_cfg_if.sink   cfg_ch
);
  import kfi_pkg::*;

  cfg_t cfg_q;
  logic busy;

  // Take register writes only while idle
  assign cfg_ch.ready = !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        CfgKeyCount:   cfg_q.key_count   <= cfg_ch.data[KeyCntW-1:0];
        CfgLoopEnable: cfg_q.loop_enable <= cfg_ch.data[0];
        CfgLoopIndex:  cfg_q.loop_index  <= cfg_ch.data[KeyIdxW-1:0];
        CfgSmoothMode: cfg_q.smooth_mode <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  kfi_core #(.MaxKeys(MaxKeys), .TimeBits(TimeBits), .ValueBits(ValueBits)) u_core (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .in_valid_i(in_ch.valid), .in_ready_o(in_ch.ready),
    .command_i(in_ch.command), .key_slot_i(in_ch.key_slot), .key_time_i(in_ch.key_time),
    .key_x_i(in_ch.key_x), .key_y_i(in_ch.key_y), .delta_ms_i(in_ch.delta_ms),
    .out_valid_o(out_ch.valid), .out_ready_i(out_ch.ready),
    .out_x_o(out_ch.out_x), .out_y_o(out_ch.out_y), .has_keys_o(out_ch.has_keys),
    .current_key_o(out_ch.current_key), .at_end_o(out_ch.at_end), .busy_o(busy)
  );
endmodule

@@ sim/tb_kfi_checker.sv @@
// Checker for the keyframe interpolator: watches the request, result and register channels,
// predicts each tick's frame and compares it field by field.
// Depends on kfi_pkg and kfi_if.
`timescale 1ns / 100ps

module tb_kfi_checker (
  input  logic clk_i,
  input  logic rst_ni,
  kfi_in_if    in_ch,
  kfi_out_if   out_ch,
  kfi_cfg_if   cfg_ch,
  output int   errors_o,
  output int   pending_o
);
  import kfi_pkg::*;

  localparam longint TimeMax = (64'd1 << TimeBitsDef) - 1;

  typedef struct {
    logic [ValueBitsDef-1:0] out_x;
    logic [ValueBitsDef-1:0] out_y;
    logic                    has_keys;
    logic [KeyIdxW-1:0]      current_key;
    logic                    at_end;
  } frame_t;

  // Shadow state of the animation engine
  longint time_tab [MaxKeysDef];
  longint x_tab    [MaxKeysDef];
  longint y_tab    [MaxKeysDef];
  longint elapsed;
  int     position;
  cfg_t   cfg;
  frame_t expected_frames [$];
  int     errors;

  assign errors_o  = errors;
  assign pending_o = expected_frames.size();

  function automatic longint blend(longint a, longint b, longint s);
    return a + (((b - a) * s + 32768) >>> 16);
  endfunction

  // Advance the clock by one tick and work out the frame it shows
  function automatic frame_t advance_clock(longint delta);
    frame_t f;
    int     n, last, pos, lk;
    longint nt, t0, span, num, t, t2, t3, t4, t5, vx, vy;
    f = '{default: '0};
    n = (cfg.key_count > MaxKeysDef) ? MaxKeysDef : cfg.key_count;
    if (n == 0) begin
      f.current_key = position[KeyIdxW-1:0];
      return f;
    end
    last = n - 1;
    pos  = (position > last) ? last : position;
    elapsed += delta;
    if (elapsed > TimeMax) elapsed = TimeMax;
    while (pos < last && elapsed >= time_tab[pos+1]) pos++;
    // Rewind to the loop keyframe, keep the overshoot
    if (cfg.loop_enable && pos >= last) begin
      lk = (cfg.loop_index > last) ? last : cfg.loop_index;
      nt = time_tab[lk] + (elapsed - time_tab[pos]);
      if (nt < 0) nt = 0;
      if (nt > TimeMax) nt = TimeMax;
      elapsed = nt;
      pos = lk;
    end
    if (pos >= last) begin
      vx = x_tab[pos];
      vy = y_tab[pos];
      f.at_end = 1'b1;
    end else begin
      t0   = time_tab[pos];
      span = time_tab[pos+1] - t0;
      num  = elapsed - t0;
      if (span <= 0 || num >= span) t = 65536;
      else if (num <= 0) t = 0;
      else t = (num * 65536) / span;
      if (cfg.smooth_mode) begin
        t2 = (t * t) >>> 16;
        t3 = (t2 * t) >>> 16;
        t4 = (t3 * t) >>> 16;
        t5 = (t4 * t) >>> 16;
        t  = 6 * t5 - 15 * t4 + 10 * t3;
        if (t < 0) t = 0;
        if (t > 65536) t = 65536;
      end
      vx = blend(x_tab[pos], x_tab[pos+1], t);
      vy = blend(y_tab[pos], y_tab[pos+1], t);
    end
    position      = pos;
    f.out_x       = vx[ValueBitsDef-1:0];
    f.out_y       = vy[ValueBitsDef-1:0];
    f.has_keys    = 1'b1;
    f.current_key = pos[KeyIdxW-1:0];
    return f;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0t] checker: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    errors++;
  endtask

  // Track requests, register writes and results
  always @(posedge clk_i or negedge rst_ni) begin
    frame_t want;
    if (!rst_ni) begin
      foreach (time_tab[i]) begin
        time_tab[i] = 0;
        x_tab[i]    = 0;
        y_tab[i]    = 0;
      end
      elapsed  = 0;
      position = 0;
      cfg      = '0;
      errors   = 0;
      expected_frames.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_idx_e'(cfg_ch.index))
          CfgKeyCount:   cfg.key_count   = cfg_ch.data[KeyCntW-1:0];
          CfgLoopEnable: cfg.loop_enable = cfg_ch.data[0];
          CfgLoopIndex:  cfg.loop_index  = cfg_ch.data[KeyIdxW-1:0];
          CfgSmoothMode: cfg.smooth_mode = cfg_ch.data[0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        if (cmd_e'(in_ch.command) == CmdLoad) begin
          time_tab[in_ch.key_slot] = longint'(in_ch.key_time);
          x_tab[in_ch.key_slot]    = longint'(in_ch.key_x);
          y_tab[in_ch.key_slot]    = longint'(in_ch.key_y);
        end else begin
          expected_frames.push_back(advance_clock(longint'(in_ch.delta_ms)));
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_frames.size() == 0) begin
          report_mismatch("unexpected result, x", out_ch.out_x, 0);
        end else begin
          want = expected_frames.pop_front();
          if (out_ch.out_x !== want.out_x) report_mismatch("out_x", out_ch.out_x, want.out_x);
          if (out_ch.out_y !== want.out_y) report_mismatch("out_y", out_ch.out_y, want.out_y);
          if (out_ch.has_keys !== want.has_keys)
            report_mismatch("has_keys", out_ch.has_keys, want.has_keys);
          if (out_ch.current_key !== want.current_key)
            report_mismatch("current_key", out_ch.current_key, want.current_key);
          if (out_ch.at_end !== want.at_end)
            report_mismatch("at_end", out_ch.at_end, want.at_end);
        end
      end
    end
  end

endmodule

@@ sim/tb_keyframe_interpolator_top.sv @@
// Testbench top for keyframe_interpolator_top: drives keyframe loads, ticks and register
// writes with random pacing and gives the verdict. Depends on kfi_pkg, kfi_if, tb_kfi_checker.
`timescale 1ns / 100ps

module tb_keyframe_interpolator_top;
  import kfi_pkg::*;

  logic clk;
  logic rst_n;
  int   errors;
  int   pending;
  bit   burst;
  int   frames_taken;

  kfi_in_if  in_ch ();
  kfi_out_if out_ch ();
  kfi_cfg_if cfg_ch ();

  keyframe_interpolator_top dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  tb_kfi_checker checker_i (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_ch    (cfg_ch),
    .errors_o  (errors),
    .pending_o (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bound the run
  initial begin
    #30ms;
    $display("** keyframe_interpolator_top: FAILED **");
    $finish;
  end

  // Result side: random stalls, quiet stretches, one long hold-off
  initial begin
    int w;
    out_ch.ready <= 1'b0;
    frames_taken = 0;
    @(posedge rst_n);
    forever begin
      if (frames_taken == 200) w = 600;
      else if ((frames_taken / 64) % 2 == 1) w = 0;
      else w = $urandom_range(0, 12);
      if (w > 0) begin
        out_ch.ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      frames_taken++;
    end
  end

  task automatic offer(cmd_e cmd, logic [3:0] slot, logic [23:0] tm, logic [23:0] x,
                       logic [23:0] y, logic [15:0] delta);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.command  <= cmd;
    in_ch.key_slot <= slot;
    in_ch.key_time <= tm;
    in_ch.key_x    <= x;
    in_ch.key_y    <= y;
    in_ch.delta_ms <= delta;
    in_ch.valid    <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic tick(logic [15:0] delta);
    offer(CmdTick, 4'($urandom), 24'($urandom), 24'($urandom), 24'($urandom), delta);
  endtask

  task automatic load(logic [3:0] slot, logic [23:0] tm, logic [23:0] x, logic [23:0] y);
    offer(CmdLoad, slot, tm, x, y, 16'($urandom));
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] data);
    in_ch.valid  <= 1'b0;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // Hold the sender until every frame is back and the block has settled
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (150) @(posedge clk);
  endtask

  task automatic configure(int count, bit loop_en, int loop_idx, bit smooth);
    drain();
    write_reg(CfgKeyCount, count | ($urandom << 5));
    write_reg(CfgLoopEnable, 32'(loop_en));
    write_reg(CfgLoopIndex, loop_idx);
    write_reg(CfgSmoothMode, 32'(smooth));
  endtask

  // Fill the table: non-decreasing times, short spans, or fully random (spans may be reversed)
  task automatic fill_table(bit scramble);
    int tm;
    tm = $urandom_range(0, 500);
    for (int s = 0; s < MaxKeysDef; s++) begin
      if (scramble) tm = $urandom;
      else if (s > 0) tm += $urandom_range(0, 2500);
      load(4'(s), 24'(tm), 24'($urandom), 24'($urandom));
    end
  endtask

  initial begin
    int count, ticks;
    bit loop_en, smooth, scramble, flood;
    rst_n          = 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.command  <= CmdLoad;
    in_ch.key_slot <= '0;
    in_ch.key_time <= '0;
    in_ch.key_x    <= '0;
    in_ch.key_y    <= '0;
    in_ch.delta_ms <= '0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.index   <= CfgKeyCount;
    cfg_ch.data    <= '0;
    burst          = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // No keys: clock stays put, nothing to show
    tick(16'hFFFF);
    tick(16'h0000);
    // Extreme values, ascending times
    for (int s = 0; s < MaxKeysDef; s++)
      load(4'(s), 24'(s * 1000), s[0] ? 24'h7FFFFF : 24'h800000,
           s[0] ? 24'h800000 : 24'h7FFFFF);
    configure(16, 1'b1, 15, 1'b0);
    for (int i = 0; i < 8; i++) tick(16'd2100);
    configure(31, 1'b0, 0, 1'b1);
    tick(16'h0000);
    tick(16'hFFFF);

    // Random phases; extreme settings first
    for (int ph = 0; ph < 12; ph++) begin
      scramble = ($urandom_range(0, 3) == 0);
      flood    = 1'b0;
      case (ph)
        0: begin count = 16; loop_en = 1; smooth = 1; end
        1: begin count = 1;  loop_en = 1; smooth = 0; end
        2: begin count = 2;  loop_en = 1; smooth = 1; end
        3: begin count = 0;  loop_en = 0; smooth = 0; end
        4: begin count = 16; loop_en = 0; smooth = 0; flood = 1; end
        default: begin
          count   = $urandom_range(0, 31);
          loop_en = ($urandom_range(0, 3) != 0);
          smooth  = 1'($urandom);
        end
      endcase
      configure(count, loop_en, (ph == 2) ? 15 : $urandom_range(0, 15), smooth);
      burst = ph[0];
      fill_table(scramble);
      ticks = flood ? 270 : 130;
      for (int i = 0; i < ticks; i++) begin
        if ($urandom_range(0, 19) == 0) begin
          load(4'($urandom), 24'(scramble ? $urandom : $urandom_range(0, 40000)),
               24'($urandom), 24'($urandom));
        end else if (flood || $urandom_range(0, 15) == 0) begin
          tick(16'($urandom));
        end else begin
          tick(16'($urandom_range(0, 3000)));
        end
      end
      burst = 1'b0;
    end

    drain();
    if (errors == 0) begin
      $display("** keyframe_interpolator_top: PASSED **");
    end else begin
      $display("** keyframe_interpolator_top: FAILED **");
    end
    $finish;
  end

endmodule
